/* design/ihex_pkg.sv */
// Shared types and constants for the Intel HEX record parser.
// No dependencies; used by the parser unit.
`default_nettype none

package ihex_pkg;

  // Status codes reported in the end-of-record result
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CHECKSUM  = 2'd1,
    STATUS_NO_COLON  = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_t;

  // Result kind
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Byte index saturation, header length, minimum record length and character position wrap
  localparam logic [8:0] BYTE_INDEX_MAX = 9'd511;
  localparam logic [8:0] HEADER_BYTES   = 9'd4;
  localparam logic [8:0] MIN_BYTES      = 9'd5;
  localparam logic [9:0] CHAR_POS_MAX   = 10'd1023;
  localparam logic [9:0] CHAR_POS_WRAP  = 10'd2;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic [7:0]  record_type;
    logic [7:0]  declared_count;
    status_t     status;
    logic        last;
  } result_t;

  // Hex digit decode: valid flag plus nibble value
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_decode(input logic [7:0] c);
    nibble_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    case (c) inside
      [8'h30:8'h39]: r.value = c[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: r.value = c[3:0] + 4'd9;
      default:       r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ihex_char_if.sv */
// Character input channel: valid/ready handshake with one text character.
// No dependencies.
`default_nettype none

interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

`default_nettype wire

/* design/ihex_result_if.sv */
// Result output channel: valid/ready handshake with one decoded result.
// No dependencies.
`default_nettype none

interface ihex_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_address;
  logic [7:0]  record_type;
  logic [7:0]  declared_count;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output kind, output data_byte, output byte_address,
                  output record_type, output declared_count, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_address,
                  input record_type, input declared_count, input status,
                  input last, output ready);
endinterface

`default_nettype wire

/* design/intel_hex_record_parser_unit.sv */
// Intel HEX record parser: one character in per transfer, data and status out.
// Depends on ihex_pkg, ihex_char_if and ihex_result_if.
// Throughput: one character per cycle while input ready is high; a line-end character
// that also completes a data byte gives two results, drained one per cycle from a
// four-entry result queue while output ready is high. Input ready is held low while
// fewer than two queue entries are free.
// Reset (synchronous, rst high) clears the parser state and empties the queue.
`default_nettype none

module intel_hex_record_parser_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  ihex_char_if.sink     in_ch,
  ihex_result_if.source out_ch
);
  import ihex_pkg::*;

  // Parser state
  logic [9:0]  char_position, char_position_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        pending_valid, pending_valid_next;
  logic [7:0]  count_field, count_field_next;
  logic [15:0] address_field, address_field_next;
  logic [7:0]  type_field, type_field_next;
  status_t     error_code, error_code_next;

  // Result queue
  result_t     queue [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fill;

  logic        in_xfer, out_xfer;
  logic        push_data, push_status;
  result_t     data_res, status_res;
  nibble_t     nib;
  logic [7:0]  byte_val;
  logic [15:0] data_addr;
  status_t     line_status;
  logic [9:0]  pos_adv;

  assign in_ch.ready = (fill <= 3'd2);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  assign nib       = hex_decode(in_ch.char_in);
  assign byte_val  = {high_nibble, nib.value};
  assign pos_adv   = (char_position >= CHAR_POS_MAX) ? CHAR_POS_WRAP
                                                     : char_position + 10'd1;
  assign data_addr = address_field + {7'd0, byte_index - MIN_BYTES};

  // Per-character decode and state update
  always_comb begin
    char_position_next = char_position;
    high_nibble_next   = high_nibble;
    byte_index_next    = byte_index;
    running_sum_next   = running_sum;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    count_field_next   = count_field;
    address_field_next = address_field;
    type_field_next    = type_field;
    error_code_next    = error_code;
    push_data          = 1'b0;

    if (in_xfer && error_code == STATUS_OK) begin
      if (char_position == 10'd0) begin
        if (in_ch.char_in != COLON_CHAR) error_code_next = STATUS_NO_COLON;
        char_position_next = 10'd1;
      end else if (!nib.valid) begin
        error_code_next = STATUS_MALFORMED;
      end else begin
        if (char_position[0]) begin
          high_nibble_next = nib.value;
        end else begin
          running_sum_next = running_sum + byte_val;
          case (byte_index)
            9'd0:    count_field_next = byte_val;
            9'd1:    address_field_next = {byte_val, 8'd0};
            9'd2:    address_field_next = {address_field[15:8], byte_val};
            9'd3:    type_field_next = byte_val;
            default: begin
              // Bytes from the fifth on pass through the one-byte delay
              push_data          = pending_valid && (byte_index >= MIN_BYTES);
              pending_byte_next  = byte_val;
              pending_valid_next = 1'b1;
            end
          endcase
          if (byte_index < BYTE_INDEX_MAX) byte_index_next = byte_index + 9'd1;
        end
        char_position_next = pos_adv;
      end
    end
  end

  // Line-end status, from the state after this character
  always_comb begin
    if (error_code_next != STATUS_OK)       line_status = error_code_next;
    else if (!char_position_next[0])        line_status = STATUS_MALFORMED;
    else if (byte_index_next < MIN_BYTES)   line_status = STATUS_MALFORMED;
    else if (running_sum_next != 8'd0)      line_status = STATUS_CHECKSUM;
    else                                    line_status = STATUS_OK;
  end

  assign push_status = in_xfer && in_ch.end_of_line;

  always_comb begin
    data_res.kind           = KIND_DATA;
    data_res.data_byte      = pending_byte;
    data_res.byte_address   = data_addr;
    data_res.record_type    = type_field_next;
    data_res.declared_count = count_field_next;
    data_res.status         = STATUS_OK;
    data_res.last           = 1'b0;

    status_res.kind           = KIND_STATUS;
    status_res.data_byte      = 8'd0;
    status_res.byte_address   = address_field_next;
    status_res.record_type    = type_field_next;
    status_res.declared_count = count_field_next;
    status_res.status         = line_status;
    status_res.last           = 1'b1;
  end

  // Parser state register; cleared at every line end
  always_ff @(posedge clk) begin
    if (rst || push_status) begin
      char_position <= '0;
      high_nibble   <= '0;
      byte_index    <= '0;
      running_sum   <= '0;
      pending_byte  <= '0;
      pending_valid <= 1'b0;
      count_field   <= '0;
      address_field <= '0;
      type_field    <= '0;
      error_code    <= STATUS_OK;
    end else begin
      char_position <= char_position_next;
      high_nibble   <= high_nibble_next;
      byte_index    <= byte_index_next;
      running_sum   <= running_sum_next;
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
      count_field   <= count_field_next;
      address_field <= address_field_next;
      type_field    <= type_field_next;
      error_code    <= error_code_next;
    end
  end

  // Result queue: data result first, then the status result
  always_ff @(posedge clk) begin
    if (push_data) queue[wr_ptr] <= data_res;
    if (push_status) begin
      if (push_data) queue[wr_ptr + 2'd1] <= status_res;
      else           queue[wr_ptr]        <= status_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + {1'b0, push_data} + {1'b0, push_status};
      if (out_xfer) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push_data} + {2'b0, push_status} - {2'b0, out_xfer};
    end
  end

  assign out_ch.valid          = (fill != 3'd0);
  assign out_ch.kind           = queue[rd_ptr].kind;
  assign out_ch.data_byte      = queue[rd_ptr].data_byte;
  assign out_ch.byte_address   = queue[rd_ptr].byte_address;
  assign out_ch.record_type    = queue[rd_ptr].record_type;
  assign out_ch.declared_count = queue[rd_ptr].declared_count;
  assign out_ch.status         = queue[rd_ptr].status;
  assign out_ch.last           = queue[rd_ptr].last;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 3'd4)
    else $error("result queue overflow");

  a_data_needs_byte: assert property (@(posedge clk) disable iff (rst)
    push_data |-> pending_valid && (byte_index >= MIN_BYTES))
    else $error("data result without a delayed byte");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    push_status |=> (char_position == 10'd0) && !pending_valid && (byte_index == 9'd0))
    else $error("parser state not cleared after line end");

  a_no_progress_on_error: assert property (@(posedge clk) disable iff (rst)
    (error_code != STATUS_OK) |-> !push_data)
    else $error("data result after an error");

  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.kind == out_ch.last) &&
                     (out_ch.kind || out_ch.status == STATUS_OK))
    else $error("malformed result");

endmodule

`default_nettype wire
